### sv/smr_pkg.sv
// ---------------------------------------------------------------------------
// smr_pkg
// Shared types, key codes and helpers for the shortcut modifier rewriter.
// ---------------------------------------------------------------------------
package smr_pkg;

  localparam int SWAP_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_REWRITE_ENABLE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OS_MODE        = 1'd1;

  // event kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;

  // host OS rule sets
  localparam logic [1:0] OS_WIN = 2'd1;
  localparam logic [1:0] OS_MAC = 2'd2;

  localparam logic [7:0] MOD_FIRST    = 8'hE0;
  localparam logic [7:0] BIT_LCTRL    = 8'h01;
  localparam logic [7:0] BIT_LSHIFT   = 8'h02;
  localparam logic [7:0] BIT_LALT     = 8'h04;
  localparam logic [7:0] BIT_LGUI     = 8'h08;
  localparam logic [7:0] BIT_RSHIFT   = 8'h20;
  localparam logic [7:0] HID_TAB      = 8'h2B;
  localparam logic [7:0] HID_LBRACKET = 8'h2F;
  localparam logic [7:0] HID_RBRACKET = 8'h30;

  // One classified event: an optional leading release, modifier releases,
  // modifier presses (each mask walked from bit 0 up) and an optional tail.
  typedef struct packed {
    logic        has_first;
    logic [7:0]  first_code;
    logic [7:0]  rel_mask;
    logic [7:0]  prs_mask;
    logic        has_final;
    logic [1:0]  final_kind;
    logic [7:0]  final_code;
    logic [63:0] time_us;
  } cmd_t;

  function automatic logic is_win_key(input logic [7:0] kc);
    logic r;
    case (kc) inside
      8'h11, 8'h17, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h1A, 8'h04, 8'h16, 8'h09,
      8'h15: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_mac_key(input logic [7:0] kc);
    logic r;
    case (kc) inside
      8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h18, 8'h12, 8'h17, 8'h13: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] low_bit(input logic [7:0] m);
    logic [2:0] r;
    r = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (m[b]) r = 3'(b);
    end
    return r;
  endfunction

endpackage

### sv/shortcut_modifier_rewriter_core.sv
// ---------------------------------------------------------------------------
// shortcut_modifier_rewriter_core
// Keyboard event rewriter: tracks modifiers and swaps OS shortcuts.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser kind, tdata code + time
//  out_    | out | out_tvalid/tready  | tuser kind, tdata code + time, tlast
//  cfg_    | in  | cfg_we             | cfg_addr index, cfg_wdata value
//
// An event gives 1 to 5 result beats; the expander sends one beat per
// cycle while the output is not held back by a low out_tready.
// Reset (rst_n low, synchronous) clears config, held modifiers, the swap
// slots and the queue.
// A two-deep command queue lets events be taken while out_tready is low.
// ---------------------------------------------------------------------------
module shortcut_modifier_rewriter_core #(
  parameter int SWAP_SLOTS = smr_pkg::SWAP_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [smr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [smr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [71:0]                    in_tdata,   // key_code[7:0], time_us[71:8]
  input  logic [1:0]                     in_tuser,   // event_kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [71:0]                    out_tdata,  // out_code[7:0], out_time_us[71:8]
  output logic [1:0]                     out_tuser,  // out_kind
  output logic                           out_tlast
);

  smr_pkg::cmd_t push_cmd, pop_cmd;
  logic          q_push, q_ready, q_pop, q_valid;
  logic [7:0]    o_code;
  logic [63:0]   o_time;

  smr_front #(.SWAP_SLOTS(SWAP_SLOTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_code  (in_tdata[7:0]),
    .in_time  (in_tdata[71:8]),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  smr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .ready   (q_ready),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_cmd (pop_cmd)
  );

  smr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_kind (out_tuser),
    .out_code (o_code),
    .out_time (o_time),
    .out_last (out_tlast)
  );

  assign out_tdata = {o_time, o_code};

endmodule

### sv/smr_front.sv
// ---------------------------------------------------------------------------
// smr_front
// Takes events, tracks held modifiers, applies the rewrite rules against the
// swap slot table and pushes one command per event into the queue.
// ---------------------------------------------------------------------------
module smr_front #(
  parameter int SWAP_SLOTS = smr_pkg::SWAP_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [smr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [smr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [7:0]                      in_code,
  input  logic [63:0]                     in_time,
  input  logic                            q_ready,
  output logic                            q_push,
  output smr_pkg::cmd_t                   q_cmd
);

  localparam int SLOT_W = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;

  logic       enable_r;
  logic [1:0] os_mode_r;
  logic [7:0] held_r, held_nxt;

  logic [7:0] orig_r  [SWAP_SLOTS];
  logic [7:0] emit_r  [SWAP_SLOTS];
  logic [7:0] synth_r [SWAP_SLOTS];
  logic [7:0] disp_r  [SWAP_SLOTS];

  logic              accept;
  logic              is_key, is_mod;
  logic              free_hit, match_hit;
  logic [SLOT_W-1:0] free_idx, match_idx;
  logic              rule_hit;
  logic [7:0]        r_emit, r_synth, r_disp, shifts;
  logic              slot_wr, slot_clr;

  assign accept   = in_valid && q_ready;
  assign in_ready = q_ready;
  assign q_push   = accept;

  assign is_key = (in_kind == smr_pkg::KIND_PRESS) || (in_kind == smr_pkg::KIND_RELEASE);
  assign is_mod = is_key && (in_code[7:3] == smr_pkg::MOD_FIRST[7:3]);

  // lowest free slot and lowest slot holding this key
  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = SWAP_SLOTS - 1; i >= 0; i--) begin
      if (orig_r[i] == 8'd0) begin
        free_hit = 1'b1;
        free_idx = SLOT_W'(i);
      end
      if (in_code != 8'd0 && orig_r[i] == in_code) begin
        match_hit = 1'b1;
        match_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rule_hit = 1'b0;
    r_emit   = in_code;
    r_synth  = 8'd0;
    r_disp   = 8'd0;
    shifts   = held_r & (smr_pkg::BIT_LSHIFT | smr_pkg::BIT_RSHIFT);
    if (os_mode_r == smr_pkg::OS_WIN && (held_r & smr_pkg::BIT_LALT) != 8'd0) begin
      if (shifts != 8'd0 && in_code == smr_pkg::HID_LBRACKET) begin
        rule_hit = 1'b1;
        r_disp   = smr_pkg::BIT_LALT | shifts;
        r_synth  = smr_pkg::BIT_LCTRL;
        r_emit   = smr_pkg::HID_TAB;
      end else if (shifts != 8'd0 && in_code == smr_pkg::HID_RBRACKET) begin
        rule_hit = 1'b1;
        r_disp   = smr_pkg::BIT_LALT;
        r_synth  = smr_pkg::BIT_LCTRL;
        r_emit   = smr_pkg::HID_TAB;
      end else if (smr_pkg::is_win_key(in_code)) begin
        rule_hit = 1'b1;
        r_disp   = smr_pkg::BIT_LALT;
        r_synth  = smr_pkg::BIT_LCTRL;
      end
    end else if (os_mode_r == smr_pkg::OS_MAC &&
                 (held_r & smr_pkg::BIT_LGUI) != 8'd0 &&
                 smr_pkg::is_mac_key(in_code)) begin
      rule_hit = 1'b1;
      r_disp   = smr_pkg::BIT_LGUI;
      r_synth  = smr_pkg::BIT_LALT;
    end
  end

  always_comb begin
    held_nxt         = held_r;
    slot_wr          = 1'b0;
    slot_clr         = 1'b0;
    q_cmd.has_first  = 1'b0;
    q_cmd.first_code = 8'd0;
    q_cmd.rel_mask   = 8'd0;
    q_cmd.prs_mask   = 8'd0;
    q_cmd.has_final  = 1'b1;
    q_cmd.final_kind = in_kind;
    q_cmd.final_code = in_code;
    q_cmd.time_us    = in_time;
    if (is_mod) begin
      if (in_kind == smr_pkg::KIND_PRESS) held_nxt = held_r | (8'd1 << in_code[2:0]);
      else held_nxt = held_r & ~(8'd1 << in_code[2:0]);
    end else if (enable_r && is_key) begin
      if (in_kind == smr_pkg::KIND_PRESS) begin
        if (rule_hit && free_hit) begin
          slot_wr          = accept;
          q_cmd.rel_mask   = r_disp;
          q_cmd.prs_mask   = r_synth;
          q_cmd.final_code = r_emit;
        end
      end else if (match_hit) begin
        slot_clr         = accept;
        q_cmd.has_first  = 1'b1;
        q_cmd.first_code = emit_r[match_idx];
        q_cmd.rel_mask   = synth_r[match_idx];
        q_cmd.prs_mask   = disp_r[match_idx] & held_r;
        q_cmd.has_final  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      os_mode_r <= 2'd0;
      held_r    <= 8'd0;
      for (int i = 0; i < SWAP_SLOTS; i++) orig_r[i] <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          smr_pkg::REG_REWRITE_ENABLE: enable_r  <= cfg_wdata[0];
          smr_pkg::REG_OS_MODE:        os_mode_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) held_r <= held_nxt;
      if (slot_wr) orig_r[free_idx] <= in_code;
      else if (slot_clr) orig_r[match_idx] <= 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_wr) begin
      emit_r[free_idx]  <= r_emit;
      synth_r[free_idx] <= r_synth;
      disp_r[free_idx]  <= r_disp;
    end
  end

  a_wr_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    slot_wr |-> orig_r[free_idx] == 8'd0 && !slot_clr)
    else $error("swap slot overwritten while in use");

endmodule

### sv/smr_queue.sv
// ---------------------------------------------------------------------------
// smr_queue
// Short command queue between the classifier and the expander.
// ---------------------------------------------------------------------------
module smr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  smr_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output smr_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = (smr_pkg::QUEUE_DEPTH > 1) ? $clog2(smr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(smr_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(smr_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(smr_pkg::QUEUE_DEPTH - 1);

  smr_pkg::cmd_t    mem_r [smr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign ready   = (count_r != DEPTH_C);
  assign valid   = (count_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ready)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("pop from empty queue");

endmodule

### sv/smr_back.sv
// ---------------------------------------------------------------------------
// smr_back
// Expands one queued command into its result beats, one beat per cycle
// while out_ready does not stall it, through a registered output stage.
// ---------------------------------------------------------------------------
module smr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  smr_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_code,
  output logic [63:0]   out_time,
  output logic          out_last
);

  smr_pkg::cmd_t cur_r, cur_nxt, stepped;
  logic          busy_r, busy_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [1:0]    okind_r;
  logic [7:0]    ocode_r;
  logic [63:0]   otime_r;
  logic          olast_r;

  logic       step, beat_last;
  logic [1:0] beat_kind;
  logic [7:0] beat_code;

  assign step = busy_r && (!ovalid_r || out_ready);

  // pick the next beat and clear it from the working copy
  always_comb begin
    stepped = cur_r;
    if (cur_r.has_first) begin
      beat_kind         = smr_pkg::KIND_RELEASE;
      beat_code         = cur_r.first_code;
      stepped.has_first = 1'b0;
    end else if (cur_r.rel_mask != 8'd0) begin
      beat_kind        = smr_pkg::KIND_RELEASE;
      beat_code        = smr_pkg::MOD_FIRST | {5'd0, smr_pkg::low_bit(cur_r.rel_mask)};
      stepped.rel_mask = cur_r.rel_mask & (cur_r.rel_mask - 8'd1);
    end else if (cur_r.prs_mask != 8'd0) begin
      beat_kind        = smr_pkg::KIND_PRESS;
      beat_code        = smr_pkg::MOD_FIRST | {5'd0, smr_pkg::low_bit(cur_r.prs_mask)};
      stepped.prs_mask = cur_r.prs_mask & (cur_r.prs_mask - 8'd1);
    end else begin
      beat_kind         = cur_r.final_kind;
      beat_code         = cur_r.final_code;
      stepped.has_final = 1'b0;
    end
    beat_last = !stepped.has_first && stepped.rel_mask == 8'd0 &&
                stepped.prs_mask == 8'd0 && !stepped.has_final;
  end

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    q_pop    = 1'b0;
    if (step) begin
      cur_nxt = stepped;
      if (beat_last) busy_nxt = 1'b0;
    end
    if ((!busy_r || (step && beat_last)) && q_valid) begin
      q_pop    = 1'b1;
      cur_nxt  = q_cmd;
      busy_nxt = 1'b1;
    end
    ovalid_nxt = ovalid_r;
    if (step) ovalid_nxt = 1'b1;
    else if (out_ready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (step) begin
      okind_r <= beat_kind;
      ocode_r <= beat_code;
      otime_r <= cur_r.time_us;
      olast_r <= beat_last;
    end
  end

  assign out_valid = ovalid_r;
  assign out_kind  = okind_r;
  assign out_code  = ocode_r;
  assign out_time  = otime_r;
  assign out_last  = olast_r;

  a_stay_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step && !beat_last |=> busy_r)
    else $error("command dropped before its last beat");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !busy_r || (step && beat_last))
    else $error("new command loaded over one still expanding");

endmodule
